### hw/rtl/nms_pkg.sv
`default_nettype none

package nms_pkg;

	localparam int MAX_COLS_DEF   = 1024;
	localparam int PIXEL_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF  = 8;

	localparam int MEAN_W  = 24;
	localparam int CNT_W   = 4;
	localparam int ROWS_W  = 16;
	localparam int COLS_W  = 11;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam int OUT_W   = ((MEAN_W + CNT_W + 7) / 8) * 8;

	localparam int DIV_STEP    = 4;
	localparam int QUEUE_DEPTH = 2;

	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;

	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	typedef struct packed {
		logic                psel;
		logic                penable;
		logic                pwrite;
		logic [PADDR_W-1:0]  paddr;
		logic [PDATA_W-1:0]  pwdata;
	} nms_apb_t;

	typedef struct packed {
		logic flush;
		logic row_ge1;
		logic row_ge2;
		logic col_ge1;
		logic col_ge2;
		logic col_last;
		logic wide;
	} nms_flags_t;

	localparam int FLAGS_W = $bits(nms_flags_t);

endpackage

`default_nettype wire

### hw/rtl/neighbour_mean_smoothing.sv
// channel  dir  beat when              payload
// apb      in   psel&penable&pwrite    image_rows at 0x0, image_cols at 0x4
// s_axis   in   s_tvalid&s_tready      tuser = cmd, tdata = pixel
// m_axis   out  m_tvalid&m_tready      tdata = {neighbour_count, mean_q8}, tlast = frame_end
//
// A pixel beat passes the back end's IDLE and LOAD states and yields 0, 1 or 2 results, each through JOB and DIV.
// A flush beat makes three line store reads and yields one result.
// D = ceil((PIXEL_BITS+FRAC_BITS+5)/4) steps of the 4-bit-per-cycle divider; D = 8 by default.
// The two-entry queue lets input beats land while the back end divides.
// Reset clears control only; line store entries are undefined until written.
// A full output register stalls the back end, a full queue drops s_tready.
`default_nettype none

module neighbour_mean_smoothing import nms_pkg::*; #(
	parameter int MAX_COLS   = MAX_COLS_DEF,
	parameter int PIXEL_BITS = PIXEL_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	localparam int IN_W      = ((PIXEL_BITS + 7) / 8) * 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [IN_W-1:0]    s_tdata,   // pixel
	input  logic               s_tuser,   // cmd
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [OUT_W-1:0]   m_tdata,   // mean_q8, neighbour_count
	output logic               m_tlast
);

	localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int QW = FLAGS_W + AW + PIXEL_BITS;

	nms_apb_t      apb;
	logic          push;
	logic [QW-1:0] push_data;
	logic          q_full;
	logic          q_empty;
	logic          q_pop;
	logic [QW-1:0] q_data;

	assign pready = 1'b1;
	assign apb    = '{psel: psel, penable: penable, pwrite: pwrite, paddr: paddr, pwdata: pwdata};

	nms_front #(
		.MAX_COLS  (MAX_COLS),
		.PIXEL_BITS(PIXEL_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.apb      (apb),
		.prdata   (prdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.pixel    (s_tdata[PIXEL_BITS-1:0]),
		.push     (push),
		.push_data(push_data),
		.q_full   (q_full)
	);

	nms_fifo #(
		.W    (QW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (push_data),
		.full  (q_full),
		.pop   (q_pop),
		.rdata (q_data),
		.empty (q_empty)
	);

	nms_back #(
		.MAX_COLS  (MAX_COLS),
		.PIXEL_BITS(PIXEL_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_data  (q_data),
		.q_pop   (q_pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

endmodule

`default_nettype wire

### hw/rtl/nms_fifo.sv
`default_nettype none

module nms_fifo import nms_pkg::*; #(
	parameter int W     = FLAGS_W,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);

	localparam int PTW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CTW = $clog2(DEPTH + 1);

	logic [W-1:0]   buf_q [DEPTH];
	logic [PTW-1:0] wp_q;
	logic [PTW-1:0] rp_q;
	logic [CTW-1:0] cnt_q;
	logic           do_push;
	logic           do_pop;

	assign full    = cnt_q == CTW'(DEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = buf_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (wp_q == PTW'(DEPTH - 1)) ? '0 : wp_q + PTW'(1);
			end
			if (do_pop) begin
				rp_q <= (rp_q == PTW'(DEPTH - 1)) ? '0 : rp_q + PTW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CTW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CTW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			buf_q[wp_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/nms_div.sv
`default_nettype none

module nms_div import nms_pkg::*; #(
	parameter int PIXEL_BITS = PIXEL_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	localparam int SW        = PIXEL_BITS + 3
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [SW-1:0]     sum,
	input  logic [CNT_W-1:0]         n,
	output logic                     done,
	output logic signed [MEAN_W-1:0] mean
);

	localparam int NW       = PIXEL_BITS + FRAC_BITS + 5;
	localparam int ITER     = (NW + DIV_STEP - 1) / DIV_STEP;
	localparam int PW       = ITER * DIV_STEP;
	localparam int CTW      = (ITER > 1) ? $clog2(ITER) : 1;
	localparam int XW       = (PW > MEAN_W + 1) ? PW : MEAN_W + 1;
	localparam int DW       = CNT_W + 1;
	localparam int MEAN_LIM = 1 << (MEAN_W - 1);

	logic [PW-1:0]    num_q;
	logic [CNT_W-1:0] rem_q;
	logic [DW-1:0]    den_q;
	logic             neg_q;
	logic             zero_q;
	logic [CTW-1:0]   cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [SW-1:0]    mag;
	logic [PW-1:0]    num_init;
	logic [PW-1:0]    num_n;
	logic [CNT_W-1:0] rem_n;
	logic [XW-1:0]    qx;
	logic [XW-1:0]    qsat;

	assign mag      = sum[SW-1] ? SW'(-sum) : SW'(sum);
	assign num_init = (PW'(mag) << (FRAC_BITS + 1)) + PW'(n);
	assign done     = done_q;

	always_comb begin
		logic [DW-1:0] t;
		num_n = num_q;
		rem_n = rem_q;
		for (int k = 0; k < DIV_STEP; k++) begin
			t     = {rem_n, num_n[PW-1]};
			num_n = {num_n[PW-2:0], 1'b0};
			if (t >= den_q) begin
				rem_n    = CNT_W'(t - den_q);
				num_n[0] = 1'b1;
			end else begin
				rem_n = CNT_W'(t);
			end
		end
	end

	always_comb begin
		qx = XW'(num_q);
		if (neg_q) begin
			qsat = (qx > XW'(MEAN_LIM)) ? XW'(MEAN_LIM) : qx;
			mean = MEAN_W'(-qsat);
		end else begin
			qsat = (qx > XW'(MEAN_LIM - 1)) ? XW'(MEAN_LIM - 1) : qx;
			mean = MEAN_W'(qsat);
		end
		if (zero_q) begin
			mean = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CTW'(1);
			if (cnt_q == CTW'(ITER - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= num_init;
			rem_q  <= '0;
			den_q  <= {n, 1'b0};
			neg_q  <= sum[SW-1];
			zero_q <= n == '0;
		end else if (busy_q) begin
			num_q <= num_n;
			rem_q <= rem_n;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/nms_front.sv
`default_nettype none

module nms_front import nms_pkg::*; #(
	parameter int MAX_COLS   = MAX_COLS_DEF,
	parameter int PIXEL_BITS = PIXEL_BITS_DEF,
	localparam int AW        = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
	localparam int QW        = FLAGS_W + AW + PIXEL_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  nms_apb_t              apb,
	output logic [PDATA_W-1:0]    prdata,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic                  s_tuser,
	input  logic [PIXEL_BITS-1:0] pixel,
	output logic                  push,
	output logic [QW-1:0]         push_data,
	input  logic                  q_full
);

	localparam int CW = $clog2(MAX_COLS + 1);

	logic [ROWS_W-1:0] rows_q;
	logic [COLS_W-1:0] cols_q;
	logic [ROWS_W-1:0] row_q;
	logic [CW-1:0]     col_q;
	logic [CW-1:0]     emit_q;

	logic              cfg_wr;
	logic [ROWS_W-1:0] rows_eff;
	logic [CW-1:0]     cols_eff;
	logic [CW-1:0]     cols_last;
	logic              cols_over;
	nms_flags_t        flags;
	logic [CW-1:0]     pos_col;

	assign cfg_wr    = apb.psel && apb.penable && apb.pwrite;
	assign prdata    = (apb.paddr[PADDR_W-1] == REG_ROWS) ? PDATA_W'(rows_q) : PDATA_W'(cols_q);
	assign s_tready  = !q_full;

	assign rows_eff  = (rows_q == '0) ? ROWS_W'(1) : rows_q;
	assign cols_over = 32'(cols_q) > 32'(MAX_COLS);
	assign cols_eff  = (cols_q == '0) ? CW'(1) : (cols_over ? CW'(MAX_COLS) : CW'(cols_q));
	assign cols_last = cols_eff - CW'(1);

	always_comb begin
		flags = '0;
		if (s_tuser == CMD_PIXEL) begin
			push           = s_tvalid && !q_full && (row_q < rows_eff) && (col_q < cols_eff);
			pos_col        = col_q;
			flags.row_ge1  = row_q != '0;
			flags.row_ge2  = row_q > ROWS_W'(1);
			flags.col_ge1  = col_q != '0;
			flags.col_ge2  = col_q > CW'(1);
			flags.col_last = col_q == cols_last;
			flags.wide     = cols_eff > CW'(1);
		end else begin
			push           = s_tvalid && !q_full && (row_q >= rows_eff) && (emit_q < cols_eff);
			pos_col        = emit_q;
			flags.flush    = 1'b1;
			flags.row_ge2  = rows_eff > ROWS_W'(1);
			flags.col_ge1  = emit_q != '0;
			flags.col_last = emit_q == cols_last;
		end
	end

	assign push_data = {flags, AW'(pos_col), pixel};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= ROWS_W'(1);
			cols_q <= COLS_W'(1);
			row_q  <= '0;
			col_q  <= '0;
			emit_q <= '0;
		end else if (cfg_wr) begin
			if (apb.paddr[PADDR_W-1] == REG_ROWS) begin
				rows_q <= apb.pwdata[ROWS_W-1:0];
			end else begin
				cols_q <= apb.pwdata[COLS_W-1:0];
			end
			row_q  <= '0;
			col_q  <= '0;
			emit_q <= '0;
		end else if (push) begin
			if (flags.flush) begin
				emit_q <= emit_q + CW'(1);
			end else if (flags.col_last) begin
				col_q <= '0;
				row_q <= row_q + ROWS_W'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/nms_back.sv
`default_nettype none

module nms_back import nms_pkg::*; #(
	parameter int MAX_COLS   = MAX_COLS_DEF,
	parameter int PIXEL_BITS = PIXEL_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	localparam int AW        = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
	localparam int QW        = FLAGS_W + AW + PIXEL_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  logic [QW-1:0]    q_data,
	output logic             q_pop,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,
	output logic             m_tlast
);

	localparam int SW = PIXEL_BITS + 3;
	localparam int PB = PIXEL_BITS;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_LOAD = 2'd1;
	localparam logic [1:0] S_JOB  = 2'd2;
	localparam logic [1:0] S_DIV  = 2'd3;

	logic [1:0]              state_q;
	nms_flags_t              flags_q;
	logic [AW-1:0]           col_q;
	logic signed [PB-1:0]    px_q;
	logic [1:0]              ld_cnt_q;
	logic                    job_mid_q;
	logic                    job_edge_q;
	logic                    job_fl_q;
	logic [CNT_W-1:0]        job_n_q;
	logic signed [PB-1:0]    win_q [3][3];
	logic [2*PB-1:0]         line_mem [MAX_COLS];
	logic [2*PB-1:0]         rd_q;
	logic                    out_valid_q;
	logic [MEAN_W-1:0]       out_mean_q;
	logic [CNT_W-1:0]        out_cnt_q;
	logic                    out_last_q;

	nms_flags_t              q_flags;
	logic [AW-1:0]           q_col;
	logic [PB-1:0]           q_px;
	logic                    rd_en;
	logic [AW-1:0]           rd_addr;
	logic                    wr_en;
	logic signed [PB-1:0]    g [3][3];
	logic [2:0]              rv;
	logic [2:0]              cv;
	logic signed [SW-1:0]    sum;
	logic [CNT_W-1:0]        nb;
	logic                    div_start;
	logic                    div_done;
	logic signed [MEAN_W-1:0] div_mean;
	logic                    out_load;

	assign q_flags = nms_flags_t'(q_data[QW-1 -: FLAGS_W]);
	assign q_col   = q_data[PB +: AW];
	assign q_px    = q_data[PB-1:0];

	assign q_pop     = (state_q == S_IDLE) && !q_empty;
	assign wr_en     = (state_q == S_LOAD) && !flags_q.flush;
	assign div_start = state_q == S_JOB;
	assign out_load  = (state_q == S_DIV) && div_done && (!out_valid_q || m_tready);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = col_q;
		if (q_pop) begin
			rd_en   = 1'b1;
			rd_addr = q_col - AW'(q_flags.flush && q_flags.col_ge1);
		end else if (state_q == S_LOAD && flags_q.flush && ld_cnt_q != 2'd2) begin
			rd_en   = 1'b1;
			rd_addr = (ld_cnt_q == 2'd0) ? col_q : col_q + AW'(!flags_q.col_last);
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				g[i][j] = win_q[i][j];
			end
		end
		rv[0] = flags_q.row_ge2;
		rv[1] = 1'b1;
		rv[2] = 1'b1;
		if (job_mid_q) begin
			cv = {1'b1, 1'b1, flags_q.col_ge2};
		end else if (job_edge_q) begin
			for (int i = 0; i < 3; i++) begin
				g[i][0] = win_q[i][1];
				g[i][1] = win_q[i][2];
				g[i][2] = '0;
			end
			cv = {1'b0, 1'b1, flags_q.wide};
		end else begin
			rv[2] = 1'b0;
			cv    = {!flags_q.col_last, 1'b1, flags_q.col_ge1};
		end
	end

	always_comb begin
		sum = '0;
		nb  = '0;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				if ((i != 1 || j != 1) && rv[i] && cv[j]) begin
					sum = sum + SW'(g[i][j]);
					nb  = nb + CNT_W'(1);
				end
			end
		end
	end

	nms_div #(
		.PIXEL_BITS(PIXEL_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.sum   (sum),
		.n     (nb),
		.done  (div_done),
		.mean  (div_mean)
	);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			line_mem[col_q] <= {rd_q[PB-1:0], px_q};
		end
		if (rd_en) begin
			rd_q <= line_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ld_cnt_q    <= '0;
			job_mid_q   <= 1'b0;
			job_edge_q  <= 1'b0;
			job_fl_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					ld_cnt_q <= '0;
					if (!q_empty) begin
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					if (!flags_q.flush) begin
						job_mid_q  <= flags_q.row_ge1 && flags_q.col_ge1;
						job_edge_q <= flags_q.row_ge1 && flags_q.col_last;
						if (flags_q.row_ge1 && (flags_q.col_ge1 || flags_q.col_last)) begin
							state_q <= S_JOB;
						end else begin
							state_q <= S_IDLE;
						end
					end else if (ld_cnt_q == 2'd2) begin
						job_fl_q <= 1'b1;
						state_q  <= S_JOB;
					end else begin
						ld_cnt_q <= ld_cnt_q + 2'd1;
					end
				end
				S_JOB: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (out_load) begin
						if (job_mid_q) begin
							job_mid_q <= 1'b0;
						end else if (job_edge_q) begin
							job_edge_q <= 1'b0;
						end else begin
							job_fl_q <= 1'b0;
						end
						state_q <= (job_mid_q && job_edge_q) ? S_JOB : S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			flags_q <= q_flags;
			col_q   <= q_col;
			px_q    <= q_px;
		end
		if (state_q == S_LOAD && (!flags_q.flush || ld_cnt_q != 2'd3)) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i][0] <= win_q[i][1];
				win_q[i][1] <= win_q[i][2];
			end
			win_q[0][2] <= rd_q[2*PB-1:PB];
			win_q[1][2] <= rd_q[PB-1:0];
			win_q[2][2] <= flags_q.flush ? '0 : px_q;
		end
		if (state_q == S_JOB) begin
			job_n_q <= nb;
		end
		if (out_load) begin
			out_mean_q <= div_mean;
			out_cnt_q  <= job_n_q;
			out_last_q <= !job_mid_q && !job_edge_q && job_fl_q && flags_q.col_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'({out_cnt_q, out_mean_q});
	assign m_tlast  = out_last_q;

endmodule

`default_nettype wire

### hw/rtl/nms_checker.sv
`default_nettype none

module nms_checker import nms_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata,
	input logic             m_tlast
);

	logic [CNT_W-1:0]  cnt;
	logic [MEAN_W-1:0] mean;

	assign cnt  = m_tdata[MEAN_W +: CNT_W];
	assign mean = m_tdata[MEAN_W-1:0];

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output beat changed while stalled");

	a_cnt_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> cnt == 4'd0 || cnt == 4'd1 || cnt == 4'd2 || cnt == 4'd3 ||
			cnt == 4'd5 || cnt == 4'd8)
		else $error("impossible neighbour count");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && cnt == 4'd0 |-> mean == '0)
		else $error("nonzero mean with no neighbours");

	a_last_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> !m_tvalid)
		else $error("beat right after frame end");

endmodule

bind neighbour_mean_smoothing nms_checker u_nms_checker (.*);

`default_nettype wire
